/* hw/rtl/cce_pkg.sv */
`default_nettype none

package cce_pkg;

  localparam int DEF_MAX_LAYER    = 64;
  localparam int DEF_MAX_KERNEL   = 9;
  localparam int DEF_SAMPLE_WIDTH = 16;

  localparam int MODE_W   = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 40;
  localparam int LSIZE_W  = 7;
  localparam int KSIZE_W  = 4;
  localparam int CFG_W    = 7;
  localparam int CFG_AW   = 1;

  localparam logic [CFG_AW-1:0] REG_LAYER_SIZE  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_KERNEL_SIZE = 1'b1;

  localparam logic [LSIZE_W-1:0] LAYER_SIZE_RST  = 7'd64;
  localparam logic [KSIZE_W-1:0] KERNEL_SIZE_RST = 4'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_KERNEL  = 2'd0,
    MODE_LAYER   = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  typedef struct packed {
    logic kwr;
    logic lwr;
    logic start;
    logic mod_step;
    logic wrap_step;
    logic mac_init;
    logic tap;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic wrap_zero;
    logic tap_last;
    logic pipe_busy;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/circular_conv2d_engine.sv */
`default_nettype none

// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------
// in       | in_valid_i/in_stall_o   | mode_i, row_i, col_i, value_i
// out      | out_valid_o/out_stall_i | result_o, out_row_o, out_col_o
// cfg      | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//
// Write items never stall the input. A compute stalls the input through six remainder
// steps, c = (K-1)/2 wrap steps, a setup step, one tap per cycle from the single-port
// stores, a drain of the product and accumulate registers and an output load.
// Reset clears control and the size registers, not the stores. A waiting result
// blocks only a compute, which holds before the output load until the result leaves.

module circular_conv2d_engine #(
  parameter int MAX_LAYER    = cce_pkg::DEF_MAX_LAYER,
  parameter int MAX_KERNEL   = cce_pkg::DEF_MAX_KERNEL,
  parameter int SAMPLE_WIDTH = cce_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cce_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  wire logic [cce_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [cce_pkg::MODE_W-1:0]         mode_i,
  input  wire logic [cce_pkg::POS_W-1:0]          row_i,
  input  wire logic [cce_pkg::POS_W-1:0]          col_i,
  input  wire logic signed [cce_pkg::VALUE_W-1:0] value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [cce_pkg::RESULT_W-1:0]     result_o,
  output logic [cce_pkg::POS_W-1:0]               out_row_o,
  output logic [cce_pkg::POS_W-1:0]               out_col_o
);

  import cce_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cce_dp #(
    .MAX_LAYER    (MAX_LAYER),
    .MAX_KERNEL   (MAX_KERNEL),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/cce_ram.sv */
`default_nettype none

module cce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/cce_ctrl.sv */
`default_nettype none

module cce_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [cce_pkg::MODE_W-1:0]    mode_i,
  output logic                               in_stall_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  input  wire cce_pkg::sts_t                 sts_i,
  output cce_pkg::cmd_t                      cmd_o
);

  import cce_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MOD  = 6'b000010,
    S_WRAP = 6'b000100,
    S_MAC  = 6'b001000,
    S_DRN  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  localparam logic [2:0] MOD_LAST = 3'(POS_W - 1);

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       out_vld_q, out_vld_d;
  logic       accept;
  cmd_t       cmd;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_KERNEL: cmd.kwr = 1'b1;
            MODE_LAYER:  cmd.lwr = 1'b1;
            MODE_COMPUTE: begin
              cmd.start = 1'b1;
              cnt_d     = '0;
              state_d   = S_MOD;
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_d        = cnt_q + 3'd1;
        if (cnt_q == MOD_LAST) begin
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        if (sts_i.wrap_zero) begin
          cmd.mac_init = 1'b1;
          state_d      = S_MAC;
        end else begin
          cmd.wrap_step = 1'b1;
        end
      end
      S_MAC: begin
        cmd.tap = 1'b1;
        if (sts_i.tap_last) begin
          state_d = S_DRN;
        end
      end
      S_DRN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          cmd.finish = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_vld_d = cmd.finish || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

/* hw/rtl/cce_dp.sv */
`default_nettype none

module cce_dp #(
  parameter int MAX_LAYER    = cce_pkg::DEF_MAX_LAYER,
  parameter int MAX_KERNEL   = cce_pkg::DEF_MAX_KERNEL,
  parameter int SAMPLE_WIDTH = cce_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cce_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  wire logic [cce_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic [cce_pkg::POS_W-1:0]          row_i,
  input  wire logic [cce_pkg::POS_W-1:0]          col_i,
  input  wire logic signed [cce_pkg::VALUE_W-1:0] value_i,
  input  wire cce_pkg::cmd_t                      cmd_i,
  output cce_pkg::sts_t                           sts_o,
  output logic signed [cce_pkg::RESULT_W-1:0]     result_o,
  output logic [cce_pkg::POS_W-1:0]               out_row_o,
  output logic [cce_pkg::POS_W-1:0]               out_col_o
);

  import cce_pkg::*;

  localparam int LW     = (MAX_LAYER > 1) ? $clog2(MAX_LAYER) : 1;
  localparam int LDEPTH = 1 << (2 * LW);
  localparam int LAW    = 2 * LW;
  localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int CEN_W  = KSIZE_W - 1;

  typedef logic [LSIZE_W-1:0] lpos_t;

  function automatic lpos_t wrap_inc(lpos_t p, lpos_t l);
    return (p == l - lpos_t'(1)) ? '0 : p + lpos_t'(1);
  endfunction

  function automatic lpos_t wrap_dec(lpos_t p, lpos_t l);
    return (p == '0) ? l - lpos_t'(1) : p - lpos_t'(1);
  endfunction

  logic [LSIZE_W-1:0] layer_size_q;
  logic [KSIZE_W-1:0] kernel_size_q;
  lpos_t              l_eff;
  logic [KSIZE_W-1:0] k_eff;

  logic [POS_W-1:0]   rsh_r_q, rsh_c_q;
  lpos_t              rem_r_q, rem_c_q, rem_r_nx, rem_c_nx;
  logic [LSIZE_W:0]   mr_t, mc_t;
  lpos_t              pos_r_q, pos_c_q;
  logic [CEN_W-1:0]   wcnt_q;
  logic [KSIZE_W-1:0] kr_q, kc_q;
  lpos_t              lr_q, lc_q;
  logic               v1_q, v2_q;

  logic               kwr_ok, lwr_ok;
  logic [KAW-1:0]     k_addr;
  logic [LAW-1:0]     l_addr;
  logic [SAMPLE_WIDTH-1:0] wdata, k_rd, l_rd;

  logic signed [PROD_W-1:0]   prod_q;
  logic signed [RESULT_W-1:0] acc_q;
  logic signed [RESULT_W-1:0] result_q;
  logic [POS_W-1:0]           orow_q, ocol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_size_q  <= LAYER_SIZE_RST;
      kernel_size_q <= KERNEL_SIZE_RST;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_LAYER_SIZE) begin
        layer_size_q <= cfg_wdata_i[LSIZE_W-1:0];
      end else if (cfg_addr_i == REG_KERNEL_SIZE) begin
        kernel_size_q <= cfg_wdata_i[KSIZE_W-1:0];
      end
    end
  end

  always_comb begin
    priority if (layer_size_q == '0) begin
      l_eff = lpos_t'(1);
    end else if (int'(layer_size_q) > MAX_LAYER) begin
      l_eff = lpos_t'(MAX_LAYER);
    end else begin
      l_eff = layer_size_q;
    end
    priority if (kernel_size_q == '0) begin
      k_eff = KSIZE_W'(1);
    end else if (int'(kernel_size_q) > MAX_KERNEL) begin
      k_eff = KSIZE_W'(MAX_KERNEL);
    end else begin
      k_eff = kernel_size_q;
    end
  end

  assign kwr_ok = cmd_i.kwr && (int'(row_i) < MAX_KERNEL) && (int'(col_i) < MAX_KERNEL);
  assign lwr_ok = cmd_i.lwr && (int'(row_i) < MAX_LAYER) && (int'(col_i) < MAX_LAYER);
  assign wdata  = SAMPLE_WIDTH'(value_i);

  assign k_addr = kwr_ok ? KAW'(int'(row_i) * MAX_KERNEL + int'(col_i))
                         : KAW'(int'(kr_q) * MAX_KERNEL + int'(kc_q));
  assign l_addr = lwr_ok ? {LW'(row_i), LW'(col_i)} : {LW'(lr_q), LW'(lc_q)};

  cce_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (KDEPTH)
  ) u_kernel_ram (
    .clk_i   (clk_i),
    .we_i    (kwr_ok),
    .addr_i  (k_addr),
    .wdata_i (wdata),
    .rdata_o (k_rd)
  );

  cce_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (LDEPTH)
  ) u_layer_ram (
    .clk_i   (clk_i),
    .we_i    (lwr_ok),
    .addr_i  (l_addr),
    .wdata_i (wdata),
    .rdata_o (l_rd)
  );

  assign mr_t     = {rem_r_q, rsh_r_q[POS_W-1]};
  assign mc_t     = {rem_c_q, rsh_c_q[POS_W-1]};
  assign rem_r_nx = (mr_t >= {1'b0, l_eff}) ? LSIZE_W'(mr_t - {1'b0, l_eff}) : LSIZE_W'(mr_t);
  assign rem_c_nx = (mc_t >= {1'b0, l_eff}) ? LSIZE_W'(mc_t - {1'b0, l_eff}) : LSIZE_W'(mc_t);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rsh_r_q <= row_i;
      rsh_c_q <= col_i;
      rem_r_q <= '0;
      rem_c_q <= '0;
      wcnt_q  <= CEN_W'((k_eff - KSIZE_W'(1)) >> 1);
    end
    if (cmd_i.mod_step) begin
      rsh_r_q <= rsh_r_q << 1;
      rsh_c_q <= rsh_c_q << 1;
      rem_r_q <= rem_r_nx;
      rem_c_q <= rem_c_nx;
      pos_r_q <= rem_r_nx;
      pos_c_q <= rem_c_nx;
    end
    if (cmd_i.wrap_step) begin
      pos_r_q <= wrap_dec(pos_r_q, l_eff);
      pos_c_q <= wrap_dec(pos_c_q, l_eff);
      wcnt_q  <= wcnt_q - CEN_W'(1);
    end
    if (cmd_i.mac_init) begin
      kr_q <= k_eff - KSIZE_W'(1);
      kc_q <= k_eff - KSIZE_W'(1);
      lr_q <= pos_r_q;
      lc_q <= pos_c_q;
    end
    if (cmd_i.tap) begin
      if (kc_q == '0) begin
        kc_q <= k_eff - KSIZE_W'(1);
        kr_q <= kr_q - KSIZE_W'(1);
        lr_q <= wrap_inc(lr_q, l_eff);
        lc_q <= pos_c_q;
      end else begin
        kc_q <= kc_q - KSIZE_W'(1);
        lc_q <= wrap_inc(lc_q, l_eff);
      end
    end
    if (v1_q) begin
      prod_q <= $signed(k_rd) * $signed(l_rd);
    end
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + RESULT_W'(prod_q);
    end
    if (cmd_i.finish) begin
      result_q <= acc_q;
      orow_q   <= POS_W'(rem_r_q);
      ocol_q   <= POS_W'(rem_c_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.tap;
      v2_q <= v1_q;
    end
  end

  assign sts_o.wrap_zero = (wcnt_q == '0);
  assign sts_o.tap_last  = (kr_q == '0) && (kc_q == '0);
  assign sts_o.pipe_busy = v1_q || v2_q;

  assign result_o  = result_q;
  assign out_row_o = orow_q;
  assign out_col_o = ocol_q;

endmodule

`default_nettype wire
